@@ hw/rtl/dbpw_pkg.sv @@
// shared types and constants of the disk brush pixel writer
// used by the top level, the address unit and the checker; depends on nothing
`default_nettype none

package dbpw_pkg;

   // store size default and byte offset width (covers the largest store and any pixel offset)
   localparam int FRAME_BYTES_DEF = 65536;
   localparam int OFF_W           = 25;

   // configuration port
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 11;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_FORMAT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_PAD_BITS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_PAD_BYTES = 3'd4;

   // request commands
   localparam logic [1:0] CMD_DRAW  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // pixel formats
   localparam logic [1:0] FMT_MONO = 2'd0;
   localparam logic [1:0] FMT_BGR  = 2'd1;

   // leftmost pixel of a byte in the one-bit format
   localparam logic [7:0] MSB_MASK = 8'h80;

   // register reset values
   localparam logic [10:0] WIDTH_RST  = 11'd64;
   localparam logic [10:0] HEIGHT_RST = 11'd64;
   localparam logic [1:0]  FORMAT_RST = FMT_BGR;

   typedef struct packed {
      logic [10:0] image_width;
      logic [10:0] image_height;
      logic [1:0]  pixel_format;
      logic [4:0]  row_pad_bits;
      logic [1:0]  row_pad_bytes;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [5:0]         brush_size;
      logic signed [11:0] pos_x;
      logic signed [11:0] pos_y;
      logic [15:0]        byte_address;
      logic [7:0]         byte_data;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [13:0] pixels_drawn;
   } rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/dbpw_frame_mem.sv @@
// byte-wide frame store, one write port and one registered read port
// depends on nothing
`default_nettype none

module dbpw_frame_mem #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/dbpw_pixel_addr.sv @@
// pixel to byte or bit offset for both pixel formats, registered
// depends on dbpw_pkg
`default_nettype none

module dbpw_pixel_addr (
   input  wire logic                       clock,
   input  wire dbpw_pkg::cfg_type          cfg,
   input  wire logic [10:0]                x,
   input  wire logic [10:0]                y,
   output logic      [dbpw_pkg::OFF_W-1:0] offset
);

   localparam int OW = dbpw_pkg::OFF_W;

   logic [12:0]   stride;
   logic [12:0]   x_term;
   logic [23:0]   row_base;
   logic [OW-1:0] offset_in;
   logic [OW-1:0] offset_ff;

   always_comb begin
      if (cfg.pixel_format == dbpw_pkg::FMT_MONO) begin
         // bit offset: row stride in bits
         stride = {2'b00, cfg.image_width} + {8'd0, cfg.row_pad_bits};
         x_term = {2'b00, x};
      end else begin
         // byte offset: three bytes a pixel
         stride = {1'b0, cfg.image_width, 1'b0} + {2'b00, cfg.image_width}
                  + {11'd0, cfg.row_pad_bytes};
         x_term = {1'b0, x, 1'b0} + {2'b00, x};
      end
      row_base  = y * stride;
      offset_in = {1'b0, row_base} + OW'(x_term);
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
   end

   assign offset = offset_ff;

endmodule

`default_nettype wire

@@ hw/rtl/disk_brush_pixel_writer.sv @@
// disk brush pixel writer top level: sequencer, config registers, store and address unit
// depends on dbpw_pkg, dbpw_frame_mem and dbpw_pixel_addr
// write, unused command, zero brush, undefined format: result next cycle; read: via ST_READ
// draw: each (2*size-1)^2 square pixel in ST_TEST, kept ones also ST_ADDR, ST_CHECK and
// ST_RMW (1-bit) or ST_WR_G, ST_WR_R (24-bit) if stored, one store port; next request taken
// in the cycle its result shows; reset: clearing pass, busy high; results cannot be stalled
`default_nettype none

module disk_brush_pixel_writer #(
   parameter int FRAME_BYTES = dbpw_pkg::FRAME_BYTES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire dbpw_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   output dbpw_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_write_en,
   input  wire logic [dbpw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [dbpw_pkg::CSR_DAT_W-1:0]   csr_wdata
);

   localparam int OW = dbpw_pkg::OFF_W;
   localparam int AW = $clog2(FRAME_BYTES);
   localparam logic [OW-1:0] FRAME_LIM = OW'(FRAME_BYTES);
   localparam logic [AW-1:0] CLR_LAST  = AW'(FRAME_BYTES - 1);

   // one-hot sequencer states
   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,  // clearing pass after reset
      ST_IDLE  = 9'b000000010,  // waiting for a request
      ST_READ  = 9'b000000100,  // store read data returning
      ST_TEST  = 9'b000001000,  // disk and image test of one square pixel
      ST_ADDR  = 9'b000010000,  // offset multiply in flight
      ST_CHECK = 9'b000100000,  // store bound check, first access
      ST_RMW   = 9'b001000000,  // one-bit format: modify and write back
      ST_WR_G  = 9'b010000000,  // 24-bit format: green byte
      ST_WR_R  = 9'b100000000   // 24-bit format: red byte
   } state_type;

   // control state
   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_cnt_ff, clr_cnt_in;
   dbpw_pkg::cfg_type cfg_ff, cfg_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // request payload and scan position
   dbpw_pkg::req_type req_ff, req_in;
   dbpw_pkg::rsp_type rsp_ff, rsp_in;
   logic [6:0]        dx_ff, dx_in;
   logic [6:0]        dy_ff, dy_in;
   logic [10:0]       x_ff, x_in;
   logic [10:0]       y_ff, y_in;
   logic [13:0]       count_ff, count_in;

   // store port
   logic          mem_wr_en;
   logic [OW-1:0] mem_wr_addr;
   logic [7:0]    mem_wr_data;
   logic          mem_rd_en;
   logic [OW-1:0] mem_rd_addr;
   logic [7:0]    mem_rd_data;

   logic [OW-1:0] offset;

   // scan helpers
   logic              accept;
   logic [5:0]        size_m1;
   logic [5:0]        new_size_m1;
   logic [6:0]        scan_edge;
   logic              last_dy;
   logic              last_dx;
   logic [12:0]       x_sum;
   logic [12:0]       y_sum;
   logic signed [13:0] dx_sq;
   logic signed [13:0] dy_sq;
   logic [14:0]       dist_sq;
   logic [11:0]       lim;
   logic              in_disk;
   logic              in_image;
   logic [OW-1:0]     byte_idx;
   logic [OW-1:0]     off_p1;
   logic [OW-1:0]     off_p2;
   logic              mono_ok;
   logic              bgr_ok;
   logic [7:0]        mono_mask;
   logic [7:0]        mono_byte;
   logic              advance;
   logic              count_inc;
   logic [13:0]       count_sum;
   logic              trivial_draw;

   dbpw_frame_mem #(
      .DEPTH (FRAME_BYTES),
      .AW    (AW)
   ) u_frame_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr[AW-1:0]),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr[AW-1:0]),
      .rd_data (mem_rd_data)
   );

   dbpw_pixel_addr u_pixel_addr (
      .clock  (clock),
      .cfg    (cfg_ff),
      .x      (x_ff),
      .y      (y_ff),
      .offset (offset)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // disk and clip test for the current square pixel
   always_comb begin
      size_m1   = req_ff.brush_size - 6'd1;
      scan_edge = {1'b0, size_m1};
      last_dy   = (dy_ff == scan_edge);
      last_dx   = (dx_ff == scan_edge);
      dx_sq     = $signed(dx_ff) * $signed(dx_ff);
      dy_sq     = $signed(dy_ff) * $signed(dy_ff);
      dist_sq   = {1'b0, dx_sq} + {1'b0, dy_sq};
      lim       = req_ff.brush_size * req_ff.brush_size;
      in_disk   = (dist_sq <= {3'b000, lim});
      // centre plus offset, 13-bit two's complement
      x_sum     = {req_ff.pos_x[11], req_ff.pos_x} + {{6{dx_ff[6]}}, dx_ff};
      y_sum     = {req_ff.pos_y[11], req_ff.pos_y} + {{6{dy_ff[6]}}, dy_ff};
      in_image  = !x_sum[12] && !y_sum[12]
                  && (x_sum[11:0] < {1'b0, cfg_ff.image_width})
                  && (y_sum[11:0] < {1'b0, cfg_ff.image_height});
   end

   // store bound checks and the modified byte of the one-bit format
   always_comb begin
      byte_idx  = {3'b000, offset[OW-1:3]};
      off_p1    = offset + OW'(1);
      off_p2    = offset + OW'(2);
      mono_ok   = (byte_idx < FRAME_LIM);
      bgr_ok    = (off_p2 < FRAME_LIM);
      mono_mask = dbpw_pkg::MSB_MASK >> offset[2:0];
      if ((req_ff.red | req_ff.green | req_ff.blue) != 8'd0) begin
         mono_byte = mem_rd_data | mono_mask;
      end else begin
         mono_byte = mem_rd_data & ~mono_mask;
      end
   end

   // configuration writes, value masked to the register width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            dbpw_pkg::REG_IMAGE_WIDTH:   cfg_in.image_width   = csr_wdata[10:0];
            dbpw_pkg::REG_IMAGE_HEIGHT:  cfg_in.image_height  = csr_wdata[10:0];
            dbpw_pkg::REG_PIXEL_FORMAT:  cfg_in.pixel_format  = csr_wdata[1:0];
            dbpw_pkg::REG_ROW_PAD_BITS:  cfg_in.row_pad_bits  = csr_wdata[4:0];
            dbpw_pkg::REG_ROW_PAD_BYTES: cfg_in.row_pad_bytes = csr_wdata[1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // main sequencer
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      count_in     = count_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = offset;
      mem_wr_data  = 8'd0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = byte_idx;
      advance      = 1'b0;
      count_inc    = 1'b0;
      new_size_m1  = req_data.brush_size - 6'd1;
      trivial_draw = (req_data.brush_size == 6'd0)
                     || ((cfg_ff.pixel_format != dbpw_pkg::FMT_MONO)
                         && (cfg_ff.pixel_format != dbpw_pkg::FMT_BGR));

      case (state_ff)
         ST_CLEAR: begin
            // zero one store byte a cycle
            mem_wr_en   = 1'b1;
            mem_wr_addr = OW'(clr_cnt_ff);
            clr_cnt_in  = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               rsp_in = '0;
               case (req_data.cmd)
                  dbpw_pkg::CMD_DRAW: begin
                     if (trivial_draw) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        // start at the top left corner of the square
                        dx_in    = 7'd0 - {1'b0, new_size_m1};
                        dy_in    = 7'd0 - {1'b0, new_size_m1};
                        count_in = 14'd0;
                        state_in = ST_TEST;
                     end
                  end
                  dbpw_pkg::CMD_WRITE: begin
                     mem_wr_en    = (OW'(req_data.byte_address) < FRAME_LIM);
                     mem_wr_addr  = OW'(req_data.byte_address);
                     mem_wr_data  = req_data.byte_data;
                     rsp_valid_in = 1'b1;
                  end
                  dbpw_pkg::CMD_READ: begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = OW'(req_data.byte_address);
                     state_in    = ST_READ;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         ST_READ: begin
            // an address beyond the store reads as zero
            rsp_valid_in = 1'b1;
            if (OW'(req_ff.byte_address) < FRAME_LIM) begin
               rsp_in.read_data = mem_rd_data;
            end
            state_in = ST_IDLE;
         end

         ST_TEST: begin
            if (in_disk && in_image) begin
               x_in     = x_sum[10:0];
               y_in     = y_sum[10:0];
               state_in = ST_ADDR;
            end else begin
               advance = 1'b1;
            end
         end

         ST_ADDR: begin
            state_in = ST_CHECK;
         end

         ST_CHECK: begin
            if ((cfg_ff.pixel_format == dbpw_pkg::FMT_MONO) && mono_ok) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = byte_idx;
               state_in    = ST_RMW;
            end else if ((cfg_ff.pixel_format == dbpw_pkg::FMT_BGR) && bgr_ok) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = offset;
               mem_wr_data = req_ff.blue;
               state_in    = ST_WR_G;
            end else begin
               // pixel past the end of the store is dropped
               advance = 1'b1;
            end
         end

         ST_RMW: begin
            // next read only after this write, so no overlap on one byte
            mem_wr_en   = 1'b1;
            mem_wr_addr = byte_idx;
            mem_wr_data = mono_byte;
            count_inc   = 1'b1;
            advance     = 1'b1;
         end

         ST_WR_G: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = off_p1;
            mem_wr_data = req_ff.green;
            state_in    = ST_WR_R;
         end

         ST_WR_R: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = off_p2;
            mem_wr_data = req_ff.red;
            count_inc   = 1'b1;
            advance     = 1'b1;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      count_sum = count_ff + {13'd0, count_inc};
      if (count_inc) begin
         count_in = count_sum;
      end

      // step y inner, x outer; finish after the bottom right corner
      if (advance) begin
         if (last_dy) begin
            dx_in = dx_ff + 7'd1;
            dy_in = 7'd0 - scan_edge;
         end else begin
            dy_in = dy_ff + 7'd1;
         end
         if (last_dx && last_dy) begin
            rsp_valid_in        = 1'b1;
            rsp_in.read_data    = 8'd0;
            rsp_in.pixels_drawn = count_sum;
            state_in            = ST_IDLE;
         end else begin
            state_in = ST_TEST;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= ST_CLEAR;
         clr_cnt_ff           <= '0;
         rsp_valid_ff         <= 1'b0;
         cfg_ff.image_width   <= dbpw_pkg::WIDTH_RST;
         cfg_ff.image_height  <= dbpw_pkg::HEIGHT_RST;
         cfg_ff.pixel_format  <= dbpw_pkg::FORMAT_RST;
         cfg_ff.row_pad_bits  <= 5'd0;
         cfg_ff.row_pad_bytes <= 2'd0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      count_ff <= count_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/dbpw_checker.sv @@
// port-level checks of the disk brush pixel writer, bound to the top level
// depends on dbpw_pkg and disk_brush_pixel_writer
`default_nettype none

module dbpw_port_checks (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire dbpw_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire dbpw_pkg::rsp_type rsp_data
);

   // clearing pass keeps requests out right after reset
   a_clear_busy: assert property (@(posedge clock) $fell(reset) |-> busy)
      else $error("not busy after reset");

   // a result only follows an accepted request or ongoing work
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start || busy))
      else $error("result without request");

   // byte write answers in the next cycle with no pixel count
   a_write_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.cmd == dbpw_pkg::CMD_WRITE)
      |=> rsp_valid && (rsp_data.pixels_drawn == 14'd0))
      else $error("write result missing");

   // byte read keeps busy high without a result, then answers with no pixel count
   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.cmd == dbpw_pkg::CMD_READ)
      |=> busy && !rsp_valid ##1 rsp_valid && (rsp_data.pixels_drawn == 14'd0))
      else $error("read result timing");

   // read data and pixel count never both nonzero
   a_rsp_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.read_data == 8'd0) || (rsp_data.pixels_drawn == 14'd0))
      else $error("mixed result fields");

endmodule

bind disk_brush_pixel_writer dbpw_port_checks u_dbpw_port_checks (.*);

`default_nettype wire
